/* sv/epg_pkg.sv */
// Package for the ellipse point generator: sizes, CORDIC arctangent table,
// configuration and rotation structs, and register index codes.
// Depends on nothing; every other file uses it, by scoped name or, in the testbench, by import.
`default_nettype none

package epg_pkg;

    // Pipeline sizing. CORDIC_STAGES may range from 8 to 24, ANGLE_BITS from 10 to 24.
    localparam int CORDIC_STAGES = 16;
    localparam int ANGLE_BITS    = 16;

    // Front-end and back-end stage counts; PIPE_DEPTH is their sum plus CORDIC_STAGES.
    localparam int ANGLE_DEPTH = 2;
    localparam int POST_DEPTH  = 4;
    localparam int PIPE_DEPTH  = ANGLE_DEPTH + CORDIC_STAGES + POST_DEPTH;

    // Binary angle resize from 16 bits to ANGLE_BITS bits.
    localparam int ANG_UP = (ANGLE_BITS >= 16) ? ANGLE_BITS - 16 : 0;
    localparam int ANG_DN = (ANGLE_BITS < 16) ? 16 - ANGLE_BITS : 0;
    localparam int Z_SH   = 32 - ANGLE_BITS;

    // CORDIC word widths: x and y in Q2.30 with headroom, z at 2^32 per turn.
    localparam int XY_W = 34;
    localparam int Z_W  = 32;

    // Start vector x = K in Q2.30.
    localparam logic signed [XY_W-1:0] X_INIT = 34'sd652032874;

    // atan(2^-i) at 2^32 per turn.
    localparam logic signed [Z_W-1:0] ATAN_TAB [24] = '{
        32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
        32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
        32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
        32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
        32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
        32'sd652,       32'sd326,       32'sd163,       32'sd81
    };

    // Quadrant codes taken from the top two angle bits.
    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEMI_AXIS_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SEMI_AXIS_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_START_ANGLE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_ANGLE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOCKWISE   = 3'd6;

    typedef struct packed {
        logic signed [19:0] center_x;
        logic signed [19:0] center_y;
        logic        [15:0] semi_axis_x;
        logic        [15:0] semi_axis_y;
        logic        [15:0] start_angle;
        logic signed [23:0] sweep_angle;
        logic               clockwise;
    } t_cfg;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic        [1:0]      quad;
    } t_rot;

endpackage

`default_nettype wire

/* sv/epg_angle.sv */
// Angle front end: sweep times progress, start angle offset, quadrant split.
// Two pipeline stages feeding the CORDIC; depends on epg_pkg.
`default_nettype none

module epg_angle (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire epg_pkg::t_cfg        i_cfg,
    input  wire logic                 i_vld,
    output logic                      o_rdy,
    input  wire logic [16:0]          i_progress,
    output logic                      o_vld,
    input  wire logic                 i_rdy,
    output epg_pkg::t_rot             o_rot
);

    localparam int AB = epg_pkg::ANGLE_BITS;

    logic              r_v [2];
    logic [1:0]        w_en;
    logic signed [41:0] w_prod;
    logic [15:0]       r_d16;
    logic [15:0]       w_a16;
    logic [AB-1:0]     w_ang;
    epg_pkg::t_rot     n_rot;
    epg_pkg::t_rot     r_rot;

    assign w_en[1] = !r_v[1] || i_rdy;
    assign w_en[0] = !r_v[0] || w_en[1];
    assign o_rdy   = w_en[0];
    assign o_vld   = r_v[1];
    assign o_rot   = r_rot;

    // Only bits 31:16 of the product matter once the angle wraps at 16 bits.
    assign w_prod = 42'(i_cfg.sweep_angle) * 42'($signed({1'b0, i_progress}));

    always_comb begin
        if (i_cfg.clockwise) begin
            w_a16 = i_cfg.start_angle - r_d16;
        end else begin
            w_a16 = i_cfg.start_angle + r_d16;
        end
        w_ang      = AB'((32'(w_a16) << epg_pkg::ANG_UP) >> epg_pkg::ANG_DN);
        n_rot.x    = epg_pkg::X_INIT;
        n_rot.y    = '0;
        n_rot.quad = w_ang[AB-1:AB-2];
        n_rot.z    = $signed(32'(w_ang[AB-3:0]) << epg_pkg::Z_SH);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
            r_v[1] <= 1'b0;
        end else begin
            if (w_en[0]) r_v[0] <= i_vld;
            if (w_en[1]) r_v[1] <= r_v[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) r_d16 <= w_prod[31:16];
        if (w_en[1]) r_rot <= n_rot;
    end

endmodule

`default_nettype wire

/* sv/epg_cordic.sv */
// Rotation-mode CORDIC, one registered stage per iteration.
// Depends on epg_pkg for the stage count, word widths and arctangent table.
`default_nettype none

module epg_cordic (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_vld,
    output logic               o_rdy,
    input  wire epg_pkg::t_rot i_rot,
    output logic               o_vld,
    input  wire logic          i_rdy,
    output epg_pkg::t_rot      o_rot
);

    localparam int N = epg_pkg::CORDIC_STAGES;

    logic          r_v   [N];
    epg_pkg::t_rot r_rot [N];
    logic [N-1:0]  w_en;

    // A stage moves when it is empty or the stage after it moves.
    always_comb begin
        w_en[N-1] = !r_v[N-1] || i_rdy;
        for (int k = N - 2; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    assign o_rdy = w_en[0];
    assign o_vld = r_v[N-1];
    assign o_rot = r_rot[N-1];

    for (genvar k = 0; k < N; k++) begin : g_stage
        epg_pkg::t_rot               w_src;
        logic                        w_vsrc;
        epg_pkg::t_rot               n_rot;
        logic signed [epg_pkg::XY_W-1:0] w_dx;
        logic signed [epg_pkg::XY_W-1:0] w_dy;

        if (k == 0) begin : g_first
            assign w_src  = i_rot;
            assign w_vsrc = i_vld;
        end else begin : g_next
            assign w_src  = r_rot[k-1];
            assign w_vsrc = r_v[k-1];
        end

        always_comb begin
            w_dx       = $signed(w_src.y) >>> k;
            w_dy       = $signed(w_src.x) >>> k;
            n_rot.quad = w_src.quad;
            if (!w_src.z[epg_pkg::Z_W-1]) begin
                n_rot.x = w_src.x - w_dx;
                n_rot.y = w_src.y + w_dy;
                n_rot.z = w_src.z - epg_pkg::ATAN_TAB[k];
            end else begin
                n_rot.x = w_src.x + w_dx;
                n_rot.y = w_src.y - w_dy;
                n_rot.z = w_src.z + epg_pkg::ATAN_TAB[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (w_en[k]) begin
                r_v[k] <= w_vsrc;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en[k]) r_rot[k] <= n_rot;
        end
    end

endmodule

`default_nettype wire

/* sv/epg_post.sv */
// Back end: quadrant fold, Q1.15 rounding, axis products, point, scale and depth.
// Four pipeline stages ending in the output register; depends on epg_pkg.
`default_nettype none

module epg_post (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire epg_pkg::t_cfg i_cfg,
    input  wire logic          i_vld,
    output logic               o_rdy,
    input  wire epg_pkg::t_rot i_rot,
    output logic               o_vld,
    input  wire logic          i_rdy,
    output logic signed [20:0] o_pos_x,
    output logic signed [20:0] o_pos_y,
    output logic [15:0]        o_scale,
    output logic [12:0]        o_depth_order
);

    localparam int W = epg_pkg::XY_W;

    logic         r_v [4];
    logic [3:0]   w_en;

    logic signed [W-1:0]  n_c, n_s, r_c, r_s;
    logic signed [16:0]   r_c15, r_s15;
    logic signed [33:0]   r_pa, r_pb;
    logic signed [31:0]   r_ps;
    logic signed [17:0]   w_dx, w_dy;
    logic signed [16:0]   w_sh;
    logic signed [17:0]   w_sc;
    logic signed [18:0]   w_dep;
    logic [15:0]          n_scale;
    logic [12:0]          n_depth;
    logic signed [20:0]   r_pos_x, r_pos_y;
    logic [15:0]          r_scale;
    logic [12:0]          r_depth;

    // Round half up to Q1.15 and clamp to plus or minus one.
    function automatic logic signed [16:0] to_q15(input logic signed [W-1:0] v);
        logic signed [W:0]  w_sum;
        logic signed [19:0] w_r;
        w_sum = (W+1)'(v) + (W+1)'(16384);
        w_r   = 20'(w_sum >>> 15);
        if (w_r > 20'sd32768) begin
            return 17'sd32767 + 17'sd1;
        end else if (w_r < -20'sd32768) begin
            return -17'sd32767 - 17'sd1;
        end
        return 17'(w_r);
    endfunction

    assign w_en[3] = !r_v[3] || i_rdy;
    assign w_en[2] = !r_v[2] || w_en[3];
    assign w_en[1] = !r_v[1] || w_en[2];
    assign w_en[0] = !r_v[0] || w_en[1];
    assign o_rdy   = w_en[0];
    assign o_vld   = r_v[3];

    always_comb begin
        unique case (i_rot.quad)
            epg_pkg::QUAD_0: begin n_c = i_rot.x;  n_s = i_rot.y;  end
            epg_pkg::QUAD_1: begin n_c = -i_rot.y; n_s = i_rot.x;  end
            epg_pkg::QUAD_2: begin n_c = -i_rot.x; n_s = -i_rot.y; end
            epg_pkg::QUAD_3: begin n_c = i_rot.y;  n_s = -i_rot.x; end
        endcase
    end

    always_comb begin
        w_dx  = 18'((r_pa + 34'sd16384) >>> 15);
        w_dy  = 18'((r_pb + 34'sd16384) >>> 15);
        w_sh  = 17'((r_ps + 32'sd32768) >>> 16);
        w_sc  = 18'sd22938 - 18'(w_sh);
        if (w_sc < 18'sd13107) begin
            n_scale = 16'd13107;
        end else if (w_sc > 18'sd32768) begin
            n_scale = 16'd32768;
        end else begin
            n_scale = 16'(w_sc);
        end
        // Depth is never negative in practice; it is clamped all the same.
        w_dep = 19'($signed({1'b0, i_cfg.semi_axis_y})) - 19'(w_dy);
        if (w_dep[18]) begin
            n_depth = '0;
        end else if (w_dep[17:4] > 14'd8191) begin
            n_depth = 13'd8191;
        end else begin
            n_depth = w_dep[16:4];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) r_v[k] <= 1'b0;
        end else begin
            if (w_en[0]) r_v[0] <= i_vld;
            if (w_en[1]) r_v[1] <= r_v[0];
            if (w_en[2]) r_v[2] <= r_v[1];
            if (w_en[3]) r_v[3] <= r_v[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_c <= n_c;
            r_s <= n_s;
        end
        if (w_en[1]) begin
            r_c15 <= to_q15(r_c);
            r_s15 <= to_q15(r_s);
        end
        if (w_en[2]) begin
            r_pa <= 34'($signed({1'b0, i_cfg.semi_axis_x})) * 34'(r_c15);
            r_pb <= 34'($signed({1'b0, i_cfg.semi_axis_y})) * 34'(r_s15);
            r_ps <= 32'sd19661 * 32'(r_s15);
        end
        if (w_en[3]) begin
            r_pos_x <= 21'(i_cfg.center_x) + 21'(w_dx);
            r_pos_y <= 21'(i_cfg.center_y) + 21'(w_dy);
            r_scale <= n_scale;
            r_depth <= n_depth;
        end
    end

    assign o_pos_x       = r_pos_x;
    assign o_pos_y       = r_pos_y;
    assign o_scale       = r_scale;
    assign o_depth_order = r_depth;

endmodule

`default_nettype wire

/* sv/ellipse_point_generator.sv */
// Top level of the ellipse point generator: configuration registers and the
// angle, CORDIC and back-end pipelines. Depends on epg_pkg, epg_angle,
// epg_cordic and epg_post.
//
// Channel   Direction  Handshake                      Payload
// config    in         i_cfg_valid / o_cfg_ready      i_cfg_index, i_cfg_data
// progress  in         i_in_valid  / o_in_ready       i_progress
// point     out        o_out_valid / i_out_ready      o_pos_x, o_pos_y, o_scale,
//                                                     o_depth_order
//
// One progress transaction is taken per cycle while o_in_ready is high, and each
// gives exactly one point transaction after passing two angle stages, one stage
// per CORDIC iteration and four back-end stages.
// Every stage holds its own valid bit and moves whenever it is empty or the
// stage after it moves, so a stalled output only fills the pipeline up behind it;
// bubbles are squeezed out and o_in_ready stays high until every stage is full.
// Synchronous active-low reset empties the pipeline and zeroes the configuration
// registers. Configuration writes are always taken (o_cfg_ready is tied high)
// and must only be made while no transaction is in flight.
`default_nettype none

module ellipse_point_generator (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [epg_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [epg_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [16:0]                   i_progress,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic signed [20:0]                 o_pos_x,
    output logic signed [20:0]                 o_pos_y,
    output logic [15:0]                        o_scale,
    output logic [12:0]                        o_depth_order
);

    epg_pkg::t_cfg r_cfg;

    logic          w_ang_vld, w_ang_rdy;
    epg_pkg::t_rot w_ang_rot;
    logic          w_cor_vld, w_cor_rdy;
    epg_pkg::t_rot w_cor_rot;

    assign o_cfg_ready = 1'b1;

    // Register writes. Indexes past the end of the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                epg_pkg::CFG_CENTER_X:    r_cfg.center_x    <= $signed(i_cfg_data[19:0]);
                epg_pkg::CFG_CENTER_Y:    r_cfg.center_y    <= $signed(i_cfg_data[19:0]);
                epg_pkg::CFG_SEMI_AXIS_X: r_cfg.semi_axis_x <= i_cfg_data[15:0];
                epg_pkg::CFG_SEMI_AXIS_Y: r_cfg.semi_axis_y <= i_cfg_data[15:0];
                epg_pkg::CFG_START_ANGLE: r_cfg.start_angle <= i_cfg_data[15:0];
                epg_pkg::CFG_SWEEP_ANGLE: r_cfg.sweep_angle <= $signed(i_cfg_data[23:0]);
                epg_pkg::CFG_CLOCKWISE:   r_cfg.clockwise   <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Angle = start +/- sweep * t, then split into quadrant and residual.
    epg_angle u_angle (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_vld      (i_in_valid),
        .o_rdy      (o_in_ready),
        .i_progress (i_progress),
        .o_vld      (w_ang_vld),
        .i_rdy      (w_ang_rdy),
        .o_rot      (w_ang_rot)
    );

    // Cosine and sine of the residual angle.
    epg_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_ang_vld),
        .o_rdy   (w_ang_rdy),
        .i_rot   (w_ang_rot),
        .o_vld   (w_cor_vld),
        .i_rdy   (w_cor_rdy),
        .o_rot   (w_cor_rot)
    );

    // Point, scale and depth order; its last stage is the output register.
    epg_post u_post (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_vld         (w_cor_vld),
        .o_rdy         (w_cor_rdy),
        .i_rot         (w_cor_rot),
        .o_vld         (o_out_valid),
        .i_rdy         (i_out_ready),
        .o_pos_x       (o_pos_x),
        .o_pos_y       (o_pos_y),
        .o_scale       (o_scale),
        .o_depth_order (o_depth_order)
    );

endmodule

`default_nettype wire

/* sv/epg_checker.sv */
// Port-level checker for the ellipse point generator, bound to the top level.
// Depends on epg_pkg for the pipeline depth.
`default_nettype none

module epg_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        o_in_ready,
    input  wire logic        o_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic [20:0] o_pos_x,
    input  wire logic [20:0] o_pos_y,
    input  wire logic [15:0] o_scale,
    input  wire logic [12:0] o_depth_order
);

    localparam int CW = $clog2(epg_pkg::PIPE_DEPTH + 1) + 1;

    logic [CW-1:0] r_cnt;
    logic [CW-1:0] n_cnt;

    // Transactions in flight: accepted inputs not yet delivered.
    assign n_cnt = r_cnt + CW'(i_in_valid && o_in_ready) - CW'(o_out_valid && i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_pos_x) &&
        $stable(o_pos_y) && $stable(o_scale) && $stable(o_depth_order))
        else $error("stalled result changed or dropped");

    a_scale_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_scale >= 16'd13107 && o_scale <= 16'd32768)
        else $error("scale out of range");

    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_cnt != '0)
        else $error("result without an accepted input");

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(epg_pkg::PIPE_DEPTH))
        else $error("more transactions in flight than pipeline stages");

endmodule

bind ellipse_point_generator epg_checker u_epg_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_pos_x       (o_pos_x),
    .o_pos_y       (o_pos_y),
    .o_scale       (o_scale),
    .o_depth_order (o_depth_order)
);

`default_nettype wire

/* test/tb_ellipse_point_generator.sv */
`timescale 1ns / 100ps
// Self-checking testbench for ellipse_point_generator: a directed table, then random
// progress transactions over several register settings and handshake idling patterns.
// Depends on epg_pkg and the ellipse_point_generator RTL.

module tb_ellipse_point_generator;

    import epg_pkg::*;

    // Cycles allowed for the pipeline to empty after the last point has been seen.
    localparam int DRAIN_CYCLES = PIPE_DEPTH + 8;
    // Extra register index past the end of the register list; the block ignores it.
    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_SPARE = 3'd7;
    // Random progress transactions sent in each idling phase.
    localparam int PHASE_ITEMS = 200;
    localparam int NUM_PHASES = 5;
    // Per-phase idle and stall percentages; the last phase adds a long receiver hold.
    localparam int SEND_IDLE_PCT [NUM_PHASES] = '{0, 51, 0, 12, 0};
    localparam int RECV_STALL_PCT [NUM_PHASES] = '{0, 0, 51, 12, 0};
    localparam int PRESSURE_HOLD = 300;

    // Angle resize from the 16-bit register angle to the CORDIC angle width.
    localparam int UP_SHIFT = (ANGLE_BITS >= 16) ? ANGLE_BITS - 16 : 0;
    localparam int DOWN_SHIFT = (ANGLE_BITS < 16) ? 16 - ANGLE_BITS : 0;
    // CORDIC gain compensation K in Q2.30 and atan(2^-i) at 2^32 per turn.
    localparam longint CORDIC_K = 652032874;
    localparam longint ATAN_Q32 [24] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    // One output point as the block presents it.
    typedef struct packed {
        logic signed [20:0] pos_x;
        logic signed [20:0] pos_y;
        logic [15:0] scale;
        logic [12:0] depth_order;
    } t_point;

    // A row of the directed table is either a register write or a progress transaction.
    // Rows marked known carry typed-in position and depth; scale then still comes from
    // the predictor.
    typedef enum logic {ROW_CFG, ROW_ITEM} t_row_kind;

    typedef struct packed {
        t_row_kind kind;
        logic [CFG_IDX_W-1:0] index;
        logic [CFG_DATA_W-1:0] data;
        logic [16:0] progress;
        logic known;
        logic signed [20:0] known_x;
        logic signed [20:0] known_y;
        logic [12:0] known_depth;
    } t_dir_row;

    localparam int DIR_ROWS = 42;

    t_dir_row directed_rows [DIR_ROWS] = '{
        // Straight out of reset every register is zero, so the point sits on the
        // origin with no depth, whatever the progress. All ones exercises the top bit.
        '{ROW_ITEM, CFG_CENTER_X, 24'h0, 17'd0, 1'b1, 21'sd0, 21'sd0, 13'd0},
        '{ROW_ITEM, CFG_CENTER_X, 24'h0, 17'd65536, 1'b1, 21'sd0, 21'sd0, 13'd0},
        '{ROW_ITEM, CFG_CENTER_X, 24'h0, 17'd131071, 1'b1, 21'sd0, 21'sd0, 13'd0},
        // Largest ellipse at the corner of the coordinate range, one full turn of sweep.
        // The center x write carries junk above bit 19 that must be dropped.
        '{ROW_CFG, CFG_CENTER_X, 24'hF80000, 17'd0, 1'b0, 21'sd0, 21'sd0, 13'd0},
        '{ROW_CFG, CFG_CENTER_Y, 24'h07FFFF, 17'd0, 1'b0, 21'sd0, 21'sd0, 13'd0},
        '{ROW_CFG, CFG_SEMI_AXIS_X, 24'h00FFFF, 17'd0, 1'b0, 21'sd0, 21'sd0, 13'd0},
        '{ROW_CFG, CFG_SEMI_AXIS_Y, 24'h00FFFF, 17'd0, 1'b0, 21'sd0, 21'sd0, 13'd0},
        '{ROW_CFG, CFG_SWEEP_ANGLE, 24'h010000, 17'd0, 1'b0, 21'sd0, 21'sd0, 13'd0},
        '{ROW_ITEM, CFG_CENTER_X, 24'h0, 17'd0, 1'b0, 21'sd0, 21'sd0, 13'd0},
        '{ROW_ITEM, CFG_CENTER_X, 24'h0, 17'd16384, 1'b0, 21'sd0, 21'sd0, 13'd0},
        '{ROW_ITEM, CFG_CENTER_X, 24'h0, 17'd32768, 1'b0, 21'sd0, 21'sd0, 13'd0},
        '{ROW_ITEM, CFG_CENTER_X, 24'h0, 17'd49152, 1'b0, 21'sd0, 21'sd0, 13'd0},
        '{ROW_ITEM, CFG_CENTER_X, 24'h0, 17'd65536, 1'b0, 21'sd0, 21'sd0, 13'd0},
        '{ROW_ITEM, CFG_CENTER_X, 24'h0, 17'd8192, 1'b0, 21'sd0, 21'sd0, 13'd0},
        '{ROW_ITEM, CFG_CENTER_X, 24'h0, 17'd1, 1'b0, 21'sd0, 21'sd0, 13'd0},
        // Flat ellipse (zero vertical semi-axis), most negative sweep, clockwise,
        // center at the opposite corner.
        '{ROW_CFG, CFG_SEMI_AXIS_Y, 24'h000000, 17'd0, 1'b0, 21'sd0, 21'sd0, 13'd0},
        '{ROW_CFG, CFG_SWEEP_ANGLE, 24'h800000, 17'd0, 1'b0, 21'sd0, 21'sd0, 13'd0},
        '{ROW_CFG, CFG_CLOCKWISE, 24'h000001, 17'd0, 1'b0, 21'sd0, 21'sd0, 13'd0},
        '{ROW_CFG, CFG_CENTER_X, 24'h07FFFF, 17'd0, 1'b0, 21'sd0, 21'sd0, 13'd0},
        '{ROW_CFG, CFG_CENTER_Y, 24'h080000, 17'd0, 1'b0, 21'sd0, 21'sd0, 13'd0},
        '{ROW_ITEM, CFG_CENTER_X, 24'h0, 17'd65536, 1'b0, 21'sd0, 21'sd0, 13'd0},
        '{ROW_ITEM, CFG_CENTER_X, 24'h0, 17'd131071, 1'b0, 21'sd0, 21'sd0, 13'd0},
        '{ROW_ITEM, CFG_CENTER_X, 24'h0, 17'd43690, 1'b0, 21'sd0, 21'sd0, 13'd0},
        // Largest start angle and sweep; the direction write has only bit 0 clear, the
        // vertical axis write has junk above bit 15, and the spare index is written.
        '{ROW_CFG, CFG_START_ANGLE, 24'h00FFFF, 17'd0, 1'b0, 21'sd0, 21'sd0, 13'd0},
        '{ROW_CFG, CFG_SWEEP_ANGLE, 24'h7FFFFF, 17'd0, 1'b0, 21'sd0, 21'sd0, 13'd0},
        '{ROW_CFG, CFG_CLOCKWISE, 24'hFFFFFE, 17'd0, 1'b0, 21'sd0, 21'sd0, 13'd0},
        '{ROW_CFG, CFG_SEMI_AXIS_X, 24'h000000, 17'd0, 1'b0, 21'sd0, 21'sd0, 13'd0},
        '{ROW_CFG, CFG_SEMI_AXIS_Y, 24'hFFFFFF, 17'd0, 1'b0, 21'sd0, 21'sd0, 13'd0},
        '{ROW_CFG, CFG_INDEX_SPARE, 24'hFFFFFF, 17'd0, 1'b0, 21'sd0, 21'sd0, 13'd0},
        '{ROW_ITEM, CFG_CENTER_X, 24'h0, 17'd1, 1'b0, 21'sd0, 21'sd0, 13'd0},
        '{ROW_ITEM, CFG_CENTER_X, 24'h0, 17'd65535, 1'b0, 21'sd0, 21'sd0, 13'd0},
        '{ROW_ITEM, CFG_CENTER_X, 24'h0, 17'd131071, 1'b0, 21'sd0, 21'sd0, 13'd0},
        '{ROW_ITEM, CFG_CENTER_X, 24'h0, 17'd30000, 1'b0, 21'sd0, 21'sd0, 13'd0},
        // Centered ellipse, quarter-turn clockwise sweep from a quarter turn, so two of the
        // angles land exactly on quadrant boundaries and the third midway between them.
        '{ROW_CFG, CFG_CENTER_X, 24'h000000, 17'd0, 1'b0, 21'sd0, 21'sd0, 13'd0},
        '{ROW_CFG, CFG_CENTER_Y, 24'h000000, 17'd0, 1'b0, 21'sd0, 21'sd0, 13'd0},
        '{ROW_CFG, CFG_SEMI_AXIS_X, 24'h001000, 17'd0, 1'b0, 21'sd0, 21'sd0, 13'd0},
        '{ROW_CFG, CFG_START_ANGLE, 24'h004000, 17'd0, 1'b0, 21'sd0, 21'sd0, 13'd0},
        '{ROW_CFG, CFG_SWEEP_ANGLE, 24'h004000, 17'd0, 1'b0, 21'sd0, 21'sd0, 13'd0},
        '{ROW_CFG, CFG_CLOCKWISE, 24'h000001, 17'd0, 1'b0, 21'sd0, 21'sd0, 13'd0},
        '{ROW_ITEM, CFG_CENTER_X, 24'h0, 17'd0, 1'b0, 21'sd0, 21'sd0, 13'd0},
        '{ROW_ITEM, CFG_CENTER_X, 24'h0, 17'd65536, 1'b0, 21'sd0, 21'sd0, 13'd0},
        '{ROW_ITEM, CFG_CENTER_X, 24'h0, 17'd32768, 1'b0, 21'sd0, 21'sd0, 13'd0}
    };

    // DUT connections. Every input starts at a known value.
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    logic [16:0] i_progress = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic signed [20:0] o_pos_x;
    logic signed [20:0] o_pos_y;
    logic [15:0] o_scale;
    logic [12:0] o_depth_order;

    // Register contents as the block should hold them, and the points still owed.
    t_cfg model_cfg = '0;
    t_point expected_points [$];
    t_point oldest_point;
    int mismatch_count = 0;
    int points_seen = 0;

    // Handshake pacing, set per phase by the stimulus process.
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_cycles = 0;

    ellipse_point_generator u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_progress    (i_progress),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_pos_x       (o_pos_x),
        .o_pos_y       (o_pos_y),
        .o_scale       (o_scale),
        .o_depth_order (o_depth_order)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Rounds a Q2.30 CORDIC output half up to Q1.15 and clamps it to plus or minus one.
    function automatic longint q30_to_q15(input longint v);
        longint r;
        r = (v + 16384) >>> 15;
        if (r > 32768) r = 32768;
        if (r < -32768) r = -32768;
        return r;
    endfunction

    // Computes the point, scale and depth for one progress value under model_cfg.
    function automatic t_point ellipse_point_of(input logic [16:0] progress);
        longint delta, ang, x, y, z, step_x, step_y, cos_q30, sin_q30;
        longint c15, s15, dx, dy, sc, depth;
        logic [15:0] angle16;
        logic [1:0] quad;
        t_point pt;
        // Swept angle is floored, then wraps modulo one turn around the start angle.
        delta = (longint'($signed(model_cfg.sweep_angle)) * longint'(progress)) >>> 16;
        if (model_cfg.clockwise)
            angle16 = model_cfg.start_angle - delta[15:0];
        else
            angle16 = model_cfg.start_angle + delta[15:0];
        ang = (longint'(angle16) << UP_SHIFT) >> DOWN_SHIFT;
        // Top two bits pick the quadrant; the remainder is rotated from (K, 0).
        quad = 2'(ang >> (ANGLE_BITS - 2));
        z = (ang & ((longint'(1) << (ANGLE_BITS - 2)) - 1)) << (32 - ANGLE_BITS);
        x = CORDIC_K;
        y = 0;
        for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
            step_x = y >>> i;
            step_y = x >>> i;
            if (z >= 0) begin
                x -= step_x;
                y += step_y;
                z -= ATAN_Q32[i];
            end else begin
                x += step_x;
                y -= step_y;
                z += ATAN_Q32[i];
            end
        end
        case (quad)
            QUAD_0: begin cos_q30 = x;  sin_q30 = y;  end
            QUAD_1: begin cos_q30 = -y; sin_q30 = x;  end
            QUAD_2: begin cos_q30 = -x; sin_q30 = -y; end
            default: begin cos_q30 = y; sin_q30 = -x; end
        endcase
        c15 = q30_to_q15(cos_q30);
        s15 = q30_to_q15(sin_q30);
        dx = (longint'(model_cfg.semi_axis_x) * c15 + 16384) >>> 15;
        dy = (longint'(model_cfg.semi_axis_y) * s15 + 16384) >>> 15;
        // Scale is 0.7 - 0.3 sin; no division, so a flat ellipse is no special case.
        sc = 22938 - ((19661 * s15 + 32768) >>> 16);
        if (sc < 13107) sc = 13107;
        if (sc > 32768) sc = 32768;
        depth = longint'(model_cfg.semi_axis_y) - dy;
        if (depth < 0) depth = 0;
        depth = depth >>> 4;
        if (depth > 8191) depth = 8191;
        pt.pos_x = 21'(longint'($signed(model_cfg.center_x)) + dx);
        pt.pos_y = 21'(longint'($signed(model_cfg.center_y)) + dy);
        pt.scale = 16'(sc);
        pt.depth_order = 13'(depth);
        return pt;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("%0t ns: point %0d: %s", $time, points_seen, what);
    endtask

    // Writes one register over the configuration channel and mirrors it in model_cfg.
    // Called at a rising edge; returns at the edge after the one that took the transaction,
    // so that the next write starts in a fresh time step.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_CENTER_X:    model_cfg.center_x = data[19:0];
            CFG_CENTER_Y:    model_cfg.center_y = data[19:0];
            CFG_SEMI_AXIS_X: model_cfg.semi_axis_x = data[15:0];
            CFG_SEMI_AXIS_Y: model_cfg.semi_axis_y = data[15:0];
            CFG_START_ANGLE: model_cfg.start_angle = data[15:0];
            CFG_SWEEP_ANGLE: model_cfg.sweep_angle = data[23:0];
            CFG_CLOCKWISE:   model_cfg.clockwise = data[0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Offers one progress transaction, after a random idle gap, and queues its point
    // once the block has taken it. Valid stays high from one transaction to the next
    // when no gap is drawn.
    task automatic send_progress(input logic [16:0] progress);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_progress <= progress;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        expected_points.push_back(ellipse_point_of(progress));
    endtask

    // Stops offering input, waits for every owed point, then lets the pipeline settle
    // so that register writes only happen while the block is idle.
    task automatic drain_points();
        i_in_valid <= 1'b0;
        while (expected_points.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Writes every register with a value drawn from zero, all ones, the sign boundary
    // of its width, one below that, or plain random bits; sometimes the spare index too.
    task automatic randomize_registers();
        int w;
        logic [CFG_DATA_W-1:0] data;
        for (int idx = CFG_CENTER_X; idx <= CFG_CLOCKWISE; idx++) begin
            case (idx)
                CFG_CENTER_X, CFG_CENTER_Y: w = 20;
                CFG_SWEEP_ANGLE: w = 24;
                CFG_CLOCKWISE: w = 1;
                default: w = 16;
            endcase
            case ($urandom_range(5))
                0: data = '0;
                1: data = '1;
                2: data = 24'(1) << (w - 1);
                3: data = (24'(1) << (w - 1)) - 24'd1;
                default: data = 24'($urandom);
            endcase
            write_register(CFG_IDX_W'(idx), data);
        end
        if ($urandom_range(1) == 1)
            write_register(CFG_INDEX_SPARE, 24'($urandom));
    endtask

    // Receiver side: stalls at random at the phase's rate, or holds off entirely
    // while a pressure hold is counting down.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Output checker: every point transaction must match the oldest owed point.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_points.size() == 0) begin
                report_mismatch("point transaction with no progress transaction pending");
            end else begin
                oldest_point = expected_points.pop_front();
                if (o_pos_x !== oldest_point.pos_x)
                    report_mismatch($sformatf("pos_x %0d, expected %0d",
                                              o_pos_x, oldest_point.pos_x));
                if (o_pos_y !== oldest_point.pos_y)
                    report_mismatch($sformatf("pos_y %0d, expected %0d",
                                              o_pos_y, oldest_point.pos_y));
                if (o_scale !== oldest_point.scale)
                    report_mismatch($sformatf("scale %0d, expected %0d",
                                              o_scale, oldest_point.scale));
                if (o_depth_order !== oldest_point.depth_order)
                    report_mismatch($sformatf("depth_order %0d, expected %0d",
                                              o_depth_order, oldest_point.depth_order));
            end
            points_seen++;
        end
    end

    // Stimulus: reset, the directed table, then the random phases.
    initial begin
        logic [16:0] progress;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table. Register rows first let the pipeline empty; known rows
        // replace position and depth of the queued point with the typed-in values.
        foreach (directed_rows[n]) begin
            if (directed_rows[n].kind == ROW_CFG) begin
                drain_points();
                write_register(directed_rows[n].index, directed_rows[n].data);
            end else begin
                send_progress(directed_rows[n].progress);
                if (directed_rows[n].known) begin
                    expected_points[$].pos_x = directed_rows[n].known_x;
                    expected_points[$].pos_y = directed_rows[n].known_y;
                    expected_points[$].depth_order = directed_rows[n].known_depth;
                end
            end
        end

        // Random phases, each with fresh register values and its own pacing. The last
        // one holds the receiver off for a long stretch while input keeps coming, so
        // the pipeline fills and o_in_ready must drop.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drain_points();
            randomize_registers();
            send_idle_pct = SEND_IDLE_PCT[ph];
            recv_stall_pct = RECV_STALL_PCT[ph];
            if (ph == NUM_PHASES - 1)
                hold_cycles = PRESSURE_HOLD;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                case ($urandom_range(9))
                    0: progress = 17'd0;
                    1: progress = 17'd65536;
                    2: progress = 17'($urandom);
                    default: progress = 17'($urandom_range(65536));
                endcase
                send_progress(progress);
            end
        end

        drain_points();
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

/* filelist.f */
sv/epg_pkg.sv
sv/epg_angle.sv
sv/epg_cordic.sv
sv/epg_post.sv
sv/ellipse_point_generator.sv
sv/epg_checker.sv
test/tb_ellipse_point_generator.sv
